>>> rtl/core/pawp_pkg.sv
// Package of types, codes and weight tables for the peer address table pick block.
package pawp_pkg;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_SUCCESS  = 3'd1,
        CMD_ATTEMPT  = 3'd2,
        CMD_PICK     = 3'd3,
        CMD_CONTAINS = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_MISS  = 2'd1,
        STS_FULL  = 2'd2,
        STS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_APPLY,
        ST_PASS1,
        ST_MUL,
        ST_MOD,
        ST_PASS2,
        ST_RD,
        ST_RDWAIT,
        ST_FINISH
    } state_t;

    localparam logic [1:0] CFG_RECENT_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_STALE_AGE      = 2'd1;
    localparam logic [1:0] CFG_STALE_FLOOR    = 2'd2;
    localparam logic [1:0] CFG_FAIL_LIMIT     = 2'd3;

    localparam int DRAW_W = 20;
    localparam int W_W    = 26;
    localparam int WM_W   = 46;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  attempts;
        logic [47:0] try_time;
        logic [47:0] succ_time;
    } entry_t;

    // 0.66^k in 24 fraction bits, the same divided by 100, and both scaled by one million
    localparam logic [24:0] POW66 [9] = '{
        25'd16777216, 25'd11072963, 25'd7308155, 25'd4823382, 25'd3183432,
        25'd2101065, 25'd1386703, 25'd915224, 25'd604048
    };
    localparam logic [24:0] POW66_D [9] = '{
        25'd167772, 25'd110729, 25'd73081, 25'd48233, 25'd31834,
        25'd21010, 25'd13867, 25'd9152, 25'd6040
    };
    localparam logic [44:0] POW66_M [9] = '{
        45'd16777216000000, 45'd11072963000000, 45'd7308155000000,
        45'd4823382000000, 45'd3183432000000, 45'd2101065000000,
        45'd1386703000000, 45'd915224000000, 45'd604048000000
    };
    localparam logic [44:0] POW66_DM [9] = '{
        45'd167772000000, 45'd110729000000, 45'd73081000000,
        45'd48233000000, 45'd31834000000, 45'd21010000000,
        45'd13867000000, 45'd9152000000, 45'd6040000000
    };

    function automatic logic [3:0] att_index(logic [7:0] att);
        return (att < 8'd8) ? att[3:0] : 4'd8;
    endfunction

    function automatic logic [W_W-1:0] weight_f(logic [7:0] att, logic recent, logic succ);
        logic [24:0] b;
        b = recent ? POW66_D[att_index(att)] : POW66[att_index(att)];
        return succ ? {b, 1'b0} : {1'b0, b};
    endfunction

    function automatic logic [WM_W-1:0] weight_m_f(logic [7:0] att, logic recent, logic succ);
        logic [44:0] b;
        b = recent ? POW66_DM[att_index(att)] : POW66_M[att_index(att)];
        return succ ? {b, 1'b0} : {1'b0, b};
    endfunction

endpackage

>>> rtl/core/pawp_if.sv
// Valid/ready channel interfaces for command beats and result beats.
interface pawp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] peer_key;
    logic [47:0] now_seconds;
    logic [19:0] random_draw;

    modport source (output valid, cmd, peer_key, now_seconds, random_draw, input ready);
    modport sink (input valid, cmd, peer_key, now_seconds, random_draw, output ready);
endinterface

interface pawp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] picked_key;
    logic        found;
    logic [6:0]  entry_total;

    modport source (output valid, status, picked_key, found, entry_total, input ready);
    modport sink (input valid, status, picked_key, found, entry_total, output ready);
endinterface

>>> rtl/core/peer_address_table_weighted_pick_top.sv
// Peer address table with weighted random pick: top level.
//
// Usage: command beats enter on req (cmd, peer_key, now_seconds, random_draw),
// one result beat per command leaves on rsp (status, picked_key, found,
// entry_total). Configuration registers are to be written on cfg_we /
// cfg_index / cfg_data only while the block is idle; nothing enforces this.
// Every command except clear first scans the key memory, one slot a cycle
// through a registered read port, and the scan ends early on a hit.
// A pick then walks the slots twice more (total, then cumulative draw) with
// one shared weight/compare unit; when every entry is terrible a 20-step
// remainder unit replaces the second walk. Clear goes straight from idle to
// the finish step. One command is worked on at a time; req.ready is high
// only while the sequencer is idle, so the next command is accepted the
// cycle after the result is loaded.
// The result sits in an output register; the next command is accepted while
// it waits, and a finished result holds in the sequencer until rsp drains.
// Reset empties the table (entry count to zero) and loads the register
// defaults; slot contents are not cleared and are never read unwritten.
module peer_address_table_weighted_pick_top
    import pawp_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    pawp_in_if.sink     req,
    pawp_out_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = W_W + AW;
    localparam int SW = TW + DRAW_W;

    // configuration
    logic [23:0] window_reg;
    logic [47:0] stale_reg;
    logic [7:0]  floor_reg;
    logic [7:0]  limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 24'd600;
            stale_reg  <= 48'd2592000;
            floor_reg  <= 8'd3;
            limit_reg  <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RECENT_WINDOW: window_reg <= cfg_data[23:0];
                CFG_STALE_AGE:     stale_reg  <= cfg_data;
                CFG_STALE_FLOOR:   floor_reg  <= cfg_data[7:0];
                CFG_FAIL_LIMIT:    limit_reg  <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // slot memory: one write port, one registered read port
    entry_t          mem [CAPACITY];
    entry_t          rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer registers
    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [63:0]     key_reg, key_next;
    logic [47:0]     now_reg, now_next;
    logic [19:0]     draw_reg, draw_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            pv_reg, pv_next;
    logic [AW-1:0]   pidx_reg, pidx_next;
    logic            hit_reg, hit_next;
    logic [AW-1:0]   hit_idx_reg, hit_idx_next;
    entry_t          hit_ent_reg, hit_ent_next;
    logic [TW-1:0]   total_reg, total_next;
    logic            any_reg, any_next;
    logic [AW-1:0]   last_reg, last_next;
    logic [SW-1:0]   thr_reg, thr_next;
    logic [SW-1:0]   cum_reg, cum_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [4:0]      bit_reg, bit_next;
    logic [AW-1:0]   tgt_reg, tgt_next;
    status_t         res_status_reg, res_status_next;
    logic [63:0]     res_key_reg, res_key_next;
    logic            res_found_reg, res_found_next;
    logic            o_vld_reg, o_vld_next;
    status_t         o_status_reg, o_status_next;
    logic [63:0]     o_key_reg, o_key_next;
    logic            o_found_reg, o_found_next;
    logic [6:0]      o_total_reg, o_total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            o_vld_reg <= 1'b0;
            idx_reg   <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            o_vld_reg <= o_vld_next;
            idx_reg   <= idx_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        now_reg        <= now_next;
        draw_reg       <= draw_next;
        pidx_reg       <= pidx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        total_reg      <= total_next;
        any_reg        <= any_next;
        last_reg       <= last_next;
        thr_reg        <= thr_next;
        cum_reg        <= cum_next;
        rem_reg        <= rem_next;
        bit_reg        <= bit_next;
        tgt_reg        <= tgt_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_found_reg  <= res_found_next;
        o_status_reg   <= o_status_next;
        o_key_reg      <= o_key_next;
        o_found_reg    <= o_found_next;
        o_total_reg    <= o_total_next;
    end

    // shared evaluation unit: scores the slot whose data just came out of memory
    logic            ev_succ, ev_later, ev_recent, ev_terrible;
    logic [47:0]     ev_since;
    logic [W_W-1:0]  ev_w;
    logic [WM_W-1:0] ev_wm;
    logic [SW-1:0]   cum_sum;
    logic [SW-1:0]   mul_res;
    logic [CW:0]     rem_sh;
    logic            issue;

    always_comb
    begin
        ev_succ     = (rd_data_reg.succ_time != 48'd0);
        ev_later    = (now_reg > rd_data_reg.try_time);
        ev_since    = ev_later ? (now_reg - rd_data_reg.try_time) : 48'd0;
        ev_recent   = (ev_since < {24'd0, window_reg});
        ev_terrible = !ev_succ &&
                      (((rd_data_reg.attempts >= floor_reg) && ev_later &&
                        (ev_since > stale_reg)) ||
                       (rd_data_reg.attempts >= limit_reg));
        ev_w        = weight_f(rd_data_reg.attempts, ev_recent, ev_succ);
        ev_wm       = weight_m_f(rd_data_reg.attempts, ev_recent, ev_succ);
        cum_sum     = cum_reg + SW'(ev_wm);
        mul_res     = draw_reg * total_reg;
        rem_sh      = {rem_reg, draw_reg[5'd19 - bit_reg]};
        issue       = (idx_reg < count_reg);
    end

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        draw_next       = draw_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        total_next      = total_reg;
        any_next        = any_reg;
        last_next       = last_reg;
        thr_next        = thr_reg;
        cum_next        = cum_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        tgt_next        = tgt_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_found_next  = res_found_reg;
        o_vld_next      = o_vld_reg;
        o_status_next   = o_status_reg;
        o_key_next      = o_key_reg;
        o_found_next    = o_found_reg;
        o_total_next    = o_total_reg;
        rd_addr         = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = hit_idx_reg;
        wr_data         = hit_ent_reg;

        // drop the output beat once taken
        if (o_vld_reg && rsp.ready)
        begin
            o_vld_next = 1'b0;
        end

        // advance the slot walk in every scan state
        if ((state_reg == ST_FIND) || (state_reg == ST_PASS1) || (state_reg == ST_PASS2))
        begin
            pv_next   = issue;
            pidx_next = idx_reg[AW-1:0];
            if (issue)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next        = cmd_t'(req.cmd);
                    key_next        = req.peer_key;
                    now_next        = req.now_seconds;
                    draw_next       = req.random_draw;
                    res_status_next = STS_OK;
                    res_key_next    = 64'd0;
                    res_found_next  = 1'b0;
                    idx_next        = '0;
                    pv_next         = 1'b0;
                    hit_next        = 1'b0;
                    if (cmd_t'(req.cmd) == CMD_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_FIND:
            begin
                if (pv_reg && (rd_data_reg.key == key_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pidx_reg;
                    hit_ent_next = rd_data_reg;
                    state_next   = ST_APPLY;
                end
                else if (!issue && !pv_reg)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                res_found_next = hit_reg;
                state_next     = ST_FINISH;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_next = STS_FULL;
                        end
                        else if (hit_reg)
                        begin
                            res_status_next = STS_MISS;
                        end
                        else
                        begin
                            wr_en             = 1'b1;
                            wr_addr           = count_reg[AW-1:0];
                            wr_data.key       = key_reg;
                            wr_data.attempts  = 8'd0;
                            wr_data.try_time  = 48'd0;
                            wr_data.succ_time = 48'd0;
                            count_next        = count_reg + 1'b1;
                            res_found_next    = 1'b1;
                        end
                    end
                    CMD_SUCCESS:
                    begin
                        if (!hit_reg)
                        begin
                            res_status_next = STS_MISS;
                        end
                        else
                        begin
                            wr_en             = 1'b1;
                            wr_data.try_time  = now_reg;
                            wr_data.succ_time = now_reg;
                        end
                    end
                    CMD_ATTEMPT:
                    begin
                        if (!hit_reg)
                        begin
                            res_status_next = STS_MISS;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_data.try_time = now_reg;
                            if (hit_ent_reg.attempts != 8'hFF)
                            begin
                                wr_data.attempts = hit_ent_reg.attempts + 8'd1;
                            end
                        end
                    end
                    CMD_PICK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STS_EMPTY;
                        end
                        else
                        begin
                            idx_next   = '0;
                            pv_next    = 1'b0;
                            total_next = '0;
                            any_next   = 1'b0;
                            state_next = ST_PASS1;
                        end
                    end
                    CMD_CONTAINS:
                    begin
                        res_status_next = hit_reg ? STS_OK : STS_MISS;
                    end
                    default:
                    begin
                        res_status_next = STS_OK;
                    end
                endcase
            end
            ST_PASS1:
            begin
                if (pv_reg && !ev_terrible)
                begin
                    total_next = total_reg + TW'(ev_w);
                    any_next   = 1'b1;
                    last_next  = pidx_reg;
                end
                if (!issue && !pv_reg)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (!any_reg)
                begin
                    rem_next   = '0;
                    bit_next   = 5'd0;
                    state_next = ST_MOD;
                end
                else
                begin
                    thr_next   = mul_res;
                    cum_next   = '0;
                    idx_next   = '0;
                    pv_next    = 1'b0;
                    state_next = ST_PASS2;
                end
            end
            ST_MOD:
            begin
                // restoring remainder, one draw bit a cycle, msb first
                if (rem_sh >= {1'b0, count_reg})
                begin
                    rem_next = CW'(rem_sh - {1'b0, count_reg});
                end
                else
                begin
                    rem_next = rem_sh[CW-1:0];
                end
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd19)
                begin
                    tgt_next   = rem_next[AW-1:0];
                    state_next = ST_RD;
                end
            end
            ST_PASS2:
            begin
                if (pv_reg && !ev_terrible)
                begin
                    cum_next = cum_sum;
                    if (thr_reg <= cum_sum)
                    begin
                        res_key_next = rd_data_reg.key;
                        state_next   = ST_FINISH;
                    end
                end
                if ((state_next == ST_PASS2) && !issue && !pv_reg)
                begin
                    tgt_next   = last_reg;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                rd_addr    = tgt_reg;
                state_next = ST_RDWAIT;
            end
            ST_RDWAIT:
            begin
                res_key_next = rd_data_reg.key;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!o_vld_reg || rsp.ready)
                begin
                    o_vld_next    = 1'b1;
                    o_status_next = res_status_reg;
                    o_key_next    = res_key_reg;
                    o_found_next  = res_found_reg;
                    o_total_next  = 7'(count_reg);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid       = o_vld_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.picked_key  = o_key_reg;
    assign rsp.found       = o_found_reg;
    assign rsp.entry_total = o_total_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + 1'b1) || (count_reg == '0)))
        else $error("entry count moved by other than one or clear");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after accepting a command");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_APPLY))
        else $error("slot write outside the apply step");
`endif

endmodule
